[rtl/jdlz_pkg.sv]
// Shared types and constants of the JDLZ stream decompressor.
// No dependencies.
package jdlz_pkg;

    localparam int unsigned HDR_LEN    = 18;
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_AW    = 3;

    localparam logic [23:0] SIZE_CAP    = 24'd8388608;
    localparam logic [7:0]  MAGIC_0     = 8'h4A;
    localparam logic [7:0]  MAGIC_1     = 8'h44;
    localparam logic [7:0]  MAGIC_2     = 8'h4C;
    localparam logic [7:0]  MAGIC_3     = 8'h5A;
    localparam logic [7:0]  HDR_VERSION = 8'd2;
    localparam logic [11:0] FAR_BIAS    = 12'h011;

    localparam logic CMD_SOURCE = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_HDR_ERR = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_BODY     = 2'd1,
        PH_DRAIN    = 2'd2,
        PH_FINISHED = 2'd3
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [23:0] total;
        logic        last;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  n;
        kind_t       k0;
        logic        use_mem;
        logic [7:0]  lit;
        logic [23:0] tot;
        logic        we;
        logic        fwd;
    } stage_t;

endpackage

[rtl/jdlz_ring_ram.sv]
// History ring: one write port, one read port with registered read data.
// Depends on nothing.
module jdlz_ring_ram #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/jdlz_out_fifo.sv]
// Result queue: takes up to two items per cycle, gives one.
// Depends on jdlz_pkg.
module jdlz_out_fifo
    import jdlz_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push0,
    input  logic             push1,
    input  result_t          in0,
    input  result_t          in1,
    input  logic             pop,
    output result_t          head,
    output logic             not_empty,
    output logic [FIFO_AW:0] count
);

    result_t             q [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [FIFO_AW:0]    cnt_reg, cnt_next;
    logic [FIFO_AW-1:0]  wptr_p1;

    assign wptr_p1   = wptr_reg + 1'b1;
    assign head      = q[rptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;

    always_comb begin
        wptr_next = wptr_reg + FIFO_AW'(push0) + FIFO_AW'(push1);
        rptr_next = rptr_reg + FIFO_AW'(pop);
        cnt_next  = cnt_reg + (FIFO_AW+1)'(push0) + (FIFO_AW+1)'(push1)
                    - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            q[wptr_reg] <= in0;
        end
        if (push1) begin
            q[wptr_p1] <= in1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

[rtl/jdlz_stream_decompressor_core.sv]
// Top level of the JDLZ stream decompressor: header check, token decode, copy drain.
// Depends on jdlz_pkg, jdlz_ring_ram and jdlz_out_fifo.
//
//  channel  | direction | tdata                          | tuser     | tlast
//  s_       | in        | source_byte                    | cmd       | end_of_source
//  m_       | out       | data_byte, total_size          | kind      | last_result
//  cfg_     | in        | output_size_limit (write only) | -         | -
//
// One item per cycle while s_tready is high: decode and ring read in the first stage, the ring read data
// returns in the second stage, which writes the ring and queues the results.
// A drain that reads the entry that the item in the second stage is writing takes forwarded data.
// Reset is synchronous; the ring is not cleared and needs no sweep.
// s_tready drops only while the result queue lacks room for two more results, plus two for an item in the second stage.
module jdlz_stream_decompressor_core
    import jdlz_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] source_byte
    input  logic        s_tuser,   // [0] cmd
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] data_byte, [31:8] total_size
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);

    logic [23:0]  limit_reg;
    phase_t       phase_reg, phase_next;
    logic [4:0]   hpos_reg, hpos_next;
    logic [7:0]   hdr_reg [HDR_LEN-1];
    logic         hdr_we;
    logic [23:0]  decl_reg, decl_next;
    logic [32:0]  rem_reg, rem_next;
    logic [8:0]   ctrl_reg, ctrl_next, rt_reg, rt_next;
    logic [1:0]   reload_reg, reload_next;
    logic [7:0]   first_reg, first_next;
    logic         await_reg, await_next;
    logic [12:0]  crem_reg, crem_next;
    logic [11:0]  dist_reg, dist_next;
    logic [23:0]  opos_reg, opos_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    stage_t       s1_reg, s1_next;
    logic [AW-1:0] s1_waddr_reg;
    logic [7:0]   lastw_reg;

    logic          acc;
    logic [AW-1:0] raddr;
    logic [AW:0]   rdiff;
    logic [7:0]    ram_q, memv, wdata;
    logic          fifo_ne;
    logic [FIFO_AW:0] fifo_cnt;
    result_t       r0, r1, head;

    assign acc   = s_tvalid && s_tready;
    assign rdiff = {1'b0, wptr_reg} - (AW+1)'(dist_reg);
    assign raddr = rdiff[AW] ? AW'(rdiff + (AW+1)'(HISTORY_DEPTH)) : rdiff[AW-1:0];
    assign s_tready = ((FIFO_AW+2)'(fifo_cnt) + (s1_reg.valid ? (FIFO_AW+2)'(2) : '0))
                      <= (FIFO_AW+2)'(FIFO_DEPTH - 2);

    always_comb begin
        logic [31:0] u, c;
        logic [23:0] lim, room;
        logic [12:0] run;
        logic [11:0] cp_dist;
        logic        tok, hok;
        logic [2:0]  used;
        phase_next  = phase_reg;
        hpos_next   = hpos_reg;
        hdr_we      = 1'b0;
        decl_next   = decl_reg;
        rem_next    = rem_reg;
        ctrl_next   = ctrl_reg;
        rt_next     = rt_reg;
        reload_next = reload_reg;
        first_next  = first_reg;
        await_next  = await_reg;
        crem_next   = crem_reg;
        dist_next   = dist_reg;
        opos_next   = opos_reg;
        wptr_next   = wptr_reg;
        s1_next     = '0;
        u    = {hdr_reg[11], hdr_reg[10], hdr_reg[9], hdr_reg[8]};
        c    = {hdr_reg[15], hdr_reg[14], hdr_reg[13], hdr_reg[12]};
        lim  = (limit_reg > SIZE_CAP) ? SIZE_CAP : limit_reg;
        room = decl_reg - opos_reg;
        hok  = 1'b0;
        tok  = 1'b0;
        used = 3'd0;
        run  = '0;
        cp_dist = '0;
        if (acc) begin
            s1_next.valid = 1'b1;
            if (s_tuser == CMD_DRAIN) begin
                if ((phase_reg == PH_BODY || phase_reg == PH_DRAIN) && crem_reg != '0) begin
                    s1_next.n       = 2'd1;
                    s1_next.k0      = KIND_BYTE;
                    s1_next.use_mem = 1'b1;
                    s1_next.we      = 1'b1;
                    s1_next.fwd     = s1_reg.valid && s1_reg.we && (raddr == s1_waddr_reg);
                    opos_next = opos_reg + 24'd1;
                    wptr_next = (wptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
                    crem_next = crem_reg - 13'd1;
                    if (crem_reg == 13'd1 && phase_reg == PH_DRAIN) begin
                        phase_next = PH_FINISHED;
                        s1_next.n  = 2'd2;
                    end
                end
            end else if (phase_reg == PH_FINISHED) begin
                s1_next.n = 2'd0;
            end else if (crem_reg != '0) begin
                s1_next.n  = 2'd1;
                s1_next.k0 = KIND_REJECT;
            end else if (phase_reg == PH_HEADER) begin
                if (hpos_reg != 5'(HDR_LEN - 1)) begin
                    hdr_we    = 1'b1;
                    hpos_next = hpos_reg + 5'd1;
                    if (s_tlast) begin
                        phase_next = PH_FINISHED;
                        s1_next.n  = 2'd1;
                        s1_next.k0 = KIND_HDR_ERR;
                    end
                end else begin
                    hok = hdr_reg[0] == MAGIC_0 && hdr_reg[1] == MAGIC_1
                          && hdr_reg[2] == MAGIC_2 && hdr_reg[3] == MAGIC_3
                          && hdr_reg[4] == HDR_VERSION && u != '0 && u <= {8'd0, lim};
                    if (!hok) begin
                        phase_next = PH_FINISHED;
                        s1_next.n  = 2'd1;
                        s1_next.k0 = KIND_HDR_ERR;
                    end else begin
                        decl_next  = u[23:0];
                        rem_next   = {1'b0, c} - 33'(HDR_LEN);
                        ctrl_next  = {1'b1, hdr_reg[16]};
                        rt_next    = {1'b1, s_tdata};
                        phase_next = PH_BODY;
                        if (s_tlast || rem_next == '0) begin
                            phase_next = PH_FINISHED;
                            s1_next.n  = 2'd1;
                            s1_next.k0 = KIND_DONE;
                        end
                    end
                end
            end else begin
                if (reload_reg[0]) begin
                    ctrl_next      = {1'b1, s_tdata};
                    reload_next[0] = 1'b0;
                end else if (reload_reg[1]) begin
                    rt_next     = {1'b1, s_tdata};
                    reload_next = 2'd0;
                end else if (await_reg) begin
                    await_next = 1'b0;
                    if (rt_reg[0]) begin
                        run     = {1'b0, first_reg[7:4], s_tdata} + 13'd3;
                        cp_dist = {8'd0, first_reg[3:0]} + 12'd1;
                    end else begin
                        cp_dist = {1'b0, first_reg[7:5], s_tdata} + FAR_BIAS;
                        run     = {8'd0, first_reg[4:0]} + 13'd3;
                    end
                    rt_next   = rt_reg >> 1;
                    dist_next = cp_dist;
                    if ({12'd0, cp_dist} > opos_reg) begin
                        crem_next = '0;
                    end else if ({11'd0, run} < room) begin
                        crem_next = run;
                    end else begin
                        crem_next = room[12:0];
                    end
                    tok  = 1'b1;
                    used = 3'd2;
                end else if (ctrl_reg[0]) begin
                    first_next = s_tdata;
                    await_next = 1'b1;
                end else begin
                    if (opos_reg < decl_reg) begin
                        s1_next.n   = 2'd1;
                        s1_next.k0  = KIND_BYTE;
                        s1_next.lit = s_tdata;
                        s1_next.we  = 1'b1;
                        opos_next = opos_reg + 24'd1;
                        wptr_next = (wptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
                    end
                    tok  = 1'b1;
                    used = 3'd1;
                end
                if (tok) begin
                    ctrl_next = ctrl_reg >> 1;
                    if (ctrl_next == 9'd1) begin
                        used = used + 3'd1;
                        reload_next[0] = 1'b1;
                    end
                    if (rt_next == 9'd1) begin
                        used = used + 3'd1;
                        reload_next[1] = 1'b1;
                    end
                    rem_next = rem_reg - 33'(used);
                end
                if (s_tlast || (reload_next == '0 && !await_next && rem_next == '0)) begin
                    if (crem_next != '0) begin
                        phase_next = PH_DRAIN;
                    end else begin
                        phase_next = PH_FINISHED;
                        if (s1_next.n == 2'd0) begin
                            s1_next.n  = 2'd1;
                            s1_next.k0 = KIND_DONE;
                        end else begin
                            s1_next.n = 2'd2;
                        end
                    end
                end
            end
            s1_next.tot = decl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hdr_we) begin
            hdr_reg[hpos_reg] <= s_tdata;
        end
        if (acc) begin
            s1_waddr_reg <= wptr_reg;
        end
        if (s1_reg.valid && s1_reg.we) begin
            lastw_reg <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg  <= SIZE_CAP;
            phase_reg  <= PH_HEADER;
            hpos_reg   <= '0;
            decl_reg   <= '0;
            rem_reg    <= '0;
            ctrl_reg   <= '0;
            rt_reg     <= '0;
            reload_reg <= '0;
            first_reg  <= '0;
            await_reg  <= 1'b0;
            crem_reg   <= '0;
            dist_reg   <= '0;
            opos_reg   <= '0;
            wptr_reg   <= '0;
            s1_reg     <= '0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            decl_reg   <= decl_next;
            rem_reg    <= rem_next;
            ctrl_reg   <= ctrl_next;
            rt_reg     <= rt_next;
            reload_reg <= reload_next;
            first_reg  <= first_next;
            await_reg  <= await_next;
            crem_reg   <= crem_next;
            dist_reg   <= dist_next;
            opos_reg   <= opos_next;
            wptr_reg   <= wptr_next;
            s1_reg     <= s1_next;
        end
    end

    jdlz_ring_ram #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_ring (
        .aclk  (aclk),
        .we    (s1_reg.valid && s1_reg.we),
        .waddr (s1_waddr_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_q)
    );

    assign memv  = s1_reg.fwd ? lastw_reg : ram_q;
    assign wdata = s1_reg.use_mem ? memv : s1_reg.lit;

    always_comb begin
        r0.kind  = s1_reg.k0;
        r0.data  = (s1_reg.k0 == KIND_BYTE) ? wdata : 8'd0;
        r0.total = (s1_reg.k0 == KIND_DONE) ? s1_reg.tot : 24'd0;
        r0.last  = (s1_reg.n == 2'd1);
        r1.kind  = KIND_DONE;
        r1.data  = 8'd0;
        r1.total = s1_reg.tot;
        r1.last  = 1'b1;
    end

    jdlz_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (s1_reg.valid && s1_reg.n != 2'd0),
        .push1     (s1_reg.valid && s1_reg.n == 2'd2),
        .in0       (r0),
        .in1       (r1),
        .pop       (m_tvalid && m_tready),
        .head      (head),
        .not_empty (fifo_ne),
        .count     (fifo_cnt)
    );

    assign m_tvalid = fifo_ne;
    assign m_tdata  = {head.total, head.data};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

`ifndef SYNTHESIS
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overflow");
    a_copy_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        crem_reg != '0 |-> (phase_reg == PH_BODY || phase_reg == PH_DRAIN))
        else $error("copy pending outside body or drain");
    a_finished_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_FINISHED |=> phase_reg == PH_FINISHED)
        else $error("left finished state without reset");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_HEADER |-> opos_reg <= decl_reg)
        else $error("output beyond declared size");
`endif

endmodule

[bench/jdlz_result_checker.sv]
// Result checker for jdlz_stream_decompressor_core: follows both stream channels and the
// config port, predicts each item's results, and compares them in order.
// Depends on jdlz_pkg for kinds, phases, magic bytes and size constants.
module jdlz_result_checker
    import jdlz_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] source_byte
    input  logic        s_tuser,   // [0] cmd
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [7:0] data_byte, [31:8] total_size
    input  logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        m_tlast,
    output int          errors,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    result_t     pending_results[$];
    logic [23:0] size_limit;
    int          hdr_pos;
    logic [7:0]  hdr[HDR_LEN];
    logic [23:0] out_size;
    logic [32:0] budget;
    logic [8:0]  ctrl_mask;
    logic [8:0]  run_mask;
    logic [1:0]  reload;
    logic [7:0]  copy_lead;
    logic        await_second;
    logic [12:0] copy_left;
    logic [11:0] copy_dist;
    logic [23:0] out_pos;
    logic [7:0]  history[4096];
    phase_t      phase;
    result_t     res[2];
    int          nres;

    assign outstanding = pending_results.size();

    initial begin
        errors = 0;
        foreach (history[i]) history[i] = 8'd0;
    end

    task automatic push_res(input kind_t k, input logic [7:0] d, input logic [23:0] t);
        res[nres] = '{kind: k, data: d, total: t, last: 1'b0};
        nres++;
    endtask

    task automatic put_history(input logic [7:0] v);
        history[out_pos[11:0]] = v;
        out_pos = out_pos + 24'd1;
    endtask

    task automatic close_decode();
        if (copy_left > 0) begin
            phase = PH_DRAIN;
        end else begin
            phase = PH_FINISHED;
            push_res(KIND_DONE, 8'd0, out_size);
        end
    endtask

    task automatic close_token(input logic [32:0] used);
        budget = budget - used;
        ctrl_mask = ctrl_mask >> 1;
        if (ctrl_mask == 9'd1) begin
            budget = budget - 33'd1;
            reload[0] = 1'b1;
        end
        if (run_mask == 9'd1) begin
            budget = budget - 33'd1;
            reload[1] = 1'b1;
        end
    endtask

    task automatic decode_header(input logic [7:0] b, input logic eos);
        logic [31:0] usz;
        logic [31:0] csz;
        logic [23:0] lim;
        hdr[hdr_pos] = b;
        hdr_pos++;
        if (hdr_pos < HDR_LEN) begin
            if (eos) begin
                phase = PH_FINISHED;
                push_res(KIND_HDR_ERR, 8'd0, 24'd0);
            end
        end else begin
            usz = {hdr[11], hdr[10], hdr[9], hdr[8]};
            csz = {hdr[15], hdr[14], hdr[13], hdr[12]};
            lim = (size_limit > SIZE_CAP) ? SIZE_CAP : size_limit;
            if (hdr[0] != MAGIC_0 || hdr[1] != MAGIC_1 || hdr[2] != MAGIC_2 ||
                hdr[3] != MAGIC_3 || hdr[4] != HDR_VERSION || usz == 0 || usz > lim) begin
                phase = PH_FINISHED;
                push_res(KIND_HDR_ERR, 8'd0, 24'd0);
            end else begin
                out_size = usz[23:0];
                budget = {1'b0, csz} - 33'd18;
                ctrl_mask = {1'b1, hdr[16]};
                run_mask = {1'b1, hdr[17]};
                phase = PH_BODY;
                if (eos || budget == 0) close_decode();
            end
        end
    endtask

    task automatic decode_body(input logic [7:0] b, input logic eos);
        logic [12:0] run;
        logic [12:0] cp_dist;
        logic [23:0] room;
        if (reload[0]) begin
            ctrl_mask = {1'b1, b};
            reload[0] = 1'b0;
        end else if (reload[1]) begin
            run_mask = {1'b1, b};
            reload = 2'd0;
        end else if (await_second) begin
            await_second = 1'b0;
            if (run_mask[0]) begin
                run = {1'b0, copy_lead[7:4], b} + 13'd3;
                cp_dist = {9'd0, copy_lead[3:0]} + 13'd1;
            end else begin
                cp_dist = {2'd0, copy_lead[7:5], b} + 13'h11;
                run = {8'd0, copy_lead[4:0]} + 13'd3;
            end
            run_mask = run_mask >> 1;
            room = out_size - out_pos;
            copy_dist = cp_dist[11:0];
            if (24'(cp_dist) > out_pos) copy_left = 13'd0;
            else copy_left = (24'(run) < room) ? run : room[12:0];
            close_token(33'd2);
        end else if (ctrl_mask[0]) begin
            copy_lead = b;
            await_second = 1'b1;
        end else begin
            if (out_pos < out_size) begin
                put_history(b);
                push_res(KIND_BYTE, b, 24'd0);
            end
            close_token(33'd1);
        end
        if (eos || (reload == 0 && !await_second && budget == 0)) close_decode();
    endtask

    task automatic predict_item(input logic cmd, input logic [7:0] b, input logic eos);
        logic [7:0] v;
        nres = 0;
        if (cmd == CMD_DRAIN) begin
            if ((phase == PH_BODY || phase == PH_DRAIN) && copy_left > 0) begin
                v = history[out_pos[11:0] - copy_dist];
                put_history(v);
                copy_left--;
                push_res(KIND_BYTE, v, 24'd0);
                if (copy_left == 0 && phase == PH_DRAIN) begin
                    phase = PH_FINISHED;
                    push_res(KIND_DONE, 8'd0, out_size);
                end
            end
        end else if (phase == PH_FINISHED) begin
            nres = 0;
        end else if (copy_left > 0) begin
            push_res(KIND_REJECT, 8'd0, 24'd0);
        end else if (phase == PH_HEADER) begin
            decode_header(b, eos);
        end else begin
            decode_body(b, eos);
        end
        if (nres > 0) res[nres - 1].last = 1'b1;
        for (int i = 0; i < nres; i++) pending_results.push_back(res[i]);
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            size_limit <= SIZE_CAP;
            hdr_pos = 0;
            out_size = '0;
            budget = '0;
            ctrl_mask = '0;
            run_mask = '0;
            reload = '0;
            copy_lead = '0;
            await_second = 1'b0;
            copy_left = '0;
            copy_dist = '0;
            out_pos = '0;
            phase = PH_HEADER;
        end else begin
            if (cfg_we) size_limit <= cfg_wdata;
            if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: kind %0d data %02h total %0d last %0b",
                             $time, m_tuser, m_tdata[7:0], m_tdata[31:8], m_tlast);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser != want.kind || m_tdata[7:0] != want.data ||
                        m_tdata[31:8] != want.total || m_tlast != want.last) begin
                        errors++;
                        $display("%0t: expected kind %0d data %02h total %0d last %0b, %s",
                                 $time, want.kind, want.data, want.total, want.last,
                                 $sformatf("got kind %0d data %02h total %0d last %0b",
                                           m_tuser, m_tdata[7:0], m_tdata[31:8], m_tlast));
                    end
                end
            end
        end
    end

endmodule

[bench/testbench.sv]
// Top of the jdlz_stream_decompressor_core bench: clock, reset, config writes and a
// generated compressed stream with drain ticks; results are judged by jdlz_result_checker.
// Depends on jdlz_pkg, the core and jdlz_result_checker.
module testbench
    import jdlz_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 800000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [23:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          errors;
    int          outstanding;
    int          cycles = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          ready_mode = 0;
    logic        hold_off = 1'b0;
    logic [8:0]  ctrl_mask;
    logic [8:0]  run_mask;

    always #6 aclk = ~aclk;

    jdlz_stream_decompressor_core dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    jdlz_result_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast), .errors(errors), .outstanding(outstanding)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("jdlz_stream_decompressor_core regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (cycles % 64 == 0) ready_mode <= $urandom_range(0, 2);
        if (!aresetn || hold_off) m_tready <= 1'b0;
        else if (ready_mode == 0) m_tready <= 1'b1;
        else if (ready_mode == 1) m_tready <= 1'($urandom_range(0, 1));
        else m_tready <= ($urandom_range(0, 3) == 0);
    end

    initial begin
        @(posedge aclk iff aresetn);
        repeat (400) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (600) @(posedge aclk);
        hold_off <= 1'b0;
    end

    task automatic send(input logic cmd, input logic [7:0] b, input logic eos);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= b;
        s_tlast <= eos;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        items_sent++;
    endtask

    task automatic write_limit(input logic [23:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // advance the local control mask past one token and feed any reload bytes
    task automatic finish_token();
        ctrl_mask = ctrl_mask >> 1;
        if (ctrl_mask == 9'd1) begin
            ctrl_mask = {1'b1, 8'($urandom)};
            send(CMD_SOURCE, ctrl_mask[7:0], 1'b0);
        end
        if (run_mask == 9'd1) begin
            run_mask = {1'b1, 8'($urandom)};
            send(CMD_SOURCE, run_mask[7:0], 1'b0);
        end
    endtask

    task automatic send_copy(input logic eos_second);
        logic [7:0] b0;
        logic [7:0] b1;
        int         run;
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        if (run_mask[0]) begin
            if ($urandom_range(0, 19) != 0) b0[7:4] = 4'd0;
            else b0[7:4] = 4'd1;
            if ($urandom_range(0, 2) != 0) b1 = 8'($urandom_range(0, 30));
            run = {b0[7:4], b1} + 3;
        end else begin
            if ($urandom_range(0, 1) != 0) b0[7:5] = 3'd0;
            run = b0[4:0] + 3;
        end
        run_mask = run_mask >> 1;
        send(CMD_SOURCE, b0, 1'b0);
        send(CMD_SOURCE, b1, eos_second);
        for (int i = 0; i < run; i++) begin
            if (i == 1 && $urandom_range(0, 15) == 0)
                send(CMD_SOURCE, 8'($urandom), 1'($urandom_range(0, 1)));
            send(CMD_DRAIN, 8'($urandom), 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 9) == 0) send(CMD_DRAIN, 8'($urandom), 1'b0);
    endtask

    initial begin
        logic [7:0]  hdr[HDR_LEN];
        logic [31:0] usz;
        logic [31:0] csz;
        int          ending;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_limit(24'd1);
        write_limit(24'hFFFFFF);
        write_limit(SIZE_CAP);
        usz = $urandom_range(700, 1600);
        write_limit(usz[23:0]);
        csz = $urandom | 32'h0001_0000;
        hdr = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, HDR_VERSION, 8'($urandom),
                8'($urandom), 8'($urandom), usz[7:0], usz[15:8], usz[23:16], usz[31:24],
                csz[7:0], csz[15:8], csz[23:16], csz[31:24], 8'($urandom), 8'($urandom)};
        ctrl_mask = {1'b1, hdr[16]};
        run_mask = {1'b1, hdr[17]};
        send(CMD_DRAIN, 8'hFF, 1'b1);
        foreach (hdr[i]) send(CMD_SOURCE, hdr[i], 1'b0);
        while (items_sent < 1300) begin
            if (ctrl_mask[0]) send_copy(1'b0);
            else send(CMD_SOURCE, 8'($urandom), 1'b0);
            finish_token();
        end
        ending = $urandom_range(0, 2);
        if (!ctrl_mask[0]) begin
            send(CMD_SOURCE, 8'($urandom), 1'b1);
        end else if (ending == 0) begin
            send(CMD_SOURCE, 8'($urandom), 1'b1);
        end else begin
            send_copy(1'b1);
        end
        repeat (8) send(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        wait (outstanding == 0);
        repeat (20) @(posedge aclk);
        write_limit(24'h000001);
        write_limit(24'h800000);
        repeat (5) @(posedge aclk);
        if (errors == 0) begin
            $display("jdlz_stream_decompressor_core regression: pass");
        end else begin
            $display("jdlz_stream_decompressor_core regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/jdlz_pkg.sv
rtl/jdlz_ring_ram.sv
rtl/jdlz_out_fifo.sv
rtl/jdlz_stream_decompressor_core.sv
bench/jdlz_result_checker.sv
bench/testbench.sv
